// ===== design/prpu_pkg.sv =====
// Shared types, constants and float32 helpers for the pull-PageRank row update unit.
// Used by the float unit, the top level and the port checker. No dependencies.
`default_nettype none

package prpu_pkg;

  localparam int unsigned NodeCountDef = 4096;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned WordW        = 32;
  localparam int unsigned InDataW      = 80;
  localparam int unsigned ModeLsb      = 0;
  localparam int unsigned IdxLsb       = 2;
  localparam int unsigned ScoreLsb     = 14;
  localparam int unsigned DegLsb       = 46;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned NormW        = 50;
  localparam int unsigned ExpW         = 12;

  localparam logic [WordW-1:0] DampingRst = 32'h3F59_999A;
  localparam logic [WordW-1:0] BaseRst    = 32'h0000_0000;
  localparam logic [WordW-1:0] CanonNan   = 32'h7FC0_0000;

  localparam logic RegDamping = 1'b0;
  localparam logic RegBase    = 1'b1;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_ACC    = 2'd1,
    MODE_FINISH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_CVT,
    OP_ADD,
    OP_MUL,
    OP_DIV
  } fpu_op_e;

  typedef struct packed {
    logic             start;
    fpu_op_e          op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } fpu_rsp_t;

  typedef struct packed {
    logic                   s;
    logic signed [ExpW-1:0] e;
    logic [23:0]            m;
    logic                   zero;
    logic                   inf;
    logic                   nan;
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [WordW-1:0] x);
    fp_unp_t u;
    u.s    = x[31];
    u.m    = {x[30:23] != 8'd0, x[22:0]};
    u.e    = (x[30:23] == 8'd0) ? $signed(ExpW'(-126))
                                : $signed({4'b0000, x[30:23]}) - $signed(ExpW'(127));
    u.zero = (x[30:0] == 31'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/prpu_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module prpu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/prpu_fpu.sv =====
// Shared iterative float32 unit: convert, add, multiply, divide, round to nearest even.
// Depends on prpu_pkg.
`default_nettype none

module prpu_fpu
  import prpu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fpu_req_t req_i,
  output fpu_rsp_t rsp_o
);

  localparam int unsigned ShW  = $clog2(NormW + 1);
  localparam int unsigned CntW = $clog2(NormW);

  typedef enum logic [3:0] {
    F_IDLE,
    F_ADD,
    F_MUL,
    F_DPRE,
    F_DIV,
    F_NORM,
    F_SHIFT,
    F_PACK,
    F_DONE
  } fstate_e;

  fstate_e                state_q, state_d;
  fp_unp_t                ua_q, ua_d, ub_q, ub_d;
  logic [NormW-1:0]       acc_q, acc_d;
  logic signed [ExpW-1:0] exp_q, exp_d;
  logic                   sgn_q, sgn_d;
  logic [24:0]            rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [23:0]            m24_q, m24_d;
  logic                   grd_q, grd_d;
  logic                   stk_q, stk_d;
  logic [7:0]             ef_q, ef_d;
  logic [WordW-1:0]       res_q, res_d;

  fp_unp_t                ua, ub;
  logic                   swap, xs, ys, lost_a, lost_r, qbit, last;
  logic [23:0]            xm, ym;
  logic signed [ExpW-1:0] xe, ye, ebias, tsh;
  logic [ExpW-1:0]        dexp;
  logic [ShW-1:0]         dsh, rsh;
  logic [NormW-1:0]       opa, opb_f, opb, sum_v, shd;
  logic [47:0]            prod;
  logic [24:0]            rsub, rnext;

  assign rsp_o.done = (state_q == F_DONE);
  assign rsp_o.res  = res_q;

  always_comb begin
    ua = fp_unpack(req_i.a);
    ub = fp_unpack(req_i.b);

    swap  = $signed(ub_q.e) > $signed(ua_q.e);
    xm    = swap ? ub_q.m : ua_q.m;
    ym    = swap ? ua_q.m : ub_q.m;
    xe    = swap ? ub_q.e : ua_q.e;
    ye    = swap ? ua_q.e : ub_q.e;
    xs    = swap ? ub_q.s : ua_q.s;
    ys    = swap ? ua_q.s : ub_q.s;
    dexp  = ExpW'(xe - ye);
    dsh   = (dexp > ExpW'(NormW)) ? ShW'(NormW) : dexp[ShW-1:0];
    opa   = {1'b0, xm, {(NormW-25){1'b0}}};
    opb_f = {1'b0, ym, {(NormW-25){1'b0}}};
    opb   = opb_f >> dsh;
    lost_a = ((opb << dsh) != opb_f);
    opb   = opb | NormW'(lost_a);
    if (xs == ys) begin
      sum_v = opa + opb;
    end else if (opa >= opb) begin
      sum_v = opa - opb;
    end else begin
      sum_v = opb - opa;
    end

    prod = ua_q.m * ub_q.m;

    qbit  = (rem_q >= {1'b0, ub_q.m});
    rsub  = qbit ? (rem_q - {1'b0, ub_q.m}) : rem_q;
    rnext = {rsub[23:0], 1'b0};
    last  = (cnt_q == CntW'(NormW - 1));

    ebias  = exp_q + $signed(ExpW'(127));
    tsh    = $signed(ExpW'(1)) - ebias;
    rsh    = (ebias > $signed(ExpW'(0))) ? '0 :
             ((tsh > $signed(ExpW'(NormW))) ? ShW'(NormW) : tsh[ShW-1:0]);
    shd    = acc_q >> rsh;
    lost_r = ((shd << rsh) != acc_q);

    state_d = state_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    acc_d   = acc_q;
    exp_d   = exp_q;
    sgn_d   = sgn_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    m24_d   = m24_q;
    grd_d   = grd_q;
    stk_d   = stk_q;
    ef_d    = ef_q;
    res_d   = res_q;

    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          ua_d    = ua;
          ub_d    = ub;
          sgn_d   = ua.s ^ ub.s;
          state_d = F_DONE;
          case (req_i.op)
            OP_CVT: begin
              if (req_i.a == '0) begin
                res_d = '0;
              end else begin
                acc_d   = {req_i.a, {(NormW-32){1'b0}}};
                exp_d   = $signed(ExpW'(31));
                sgn_d   = 1'b0;
                state_d = F_NORM;
              end
            end
            OP_ADD: begin
              if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.s != ub.s))) begin
                res_d = CanonNan;
              end else if (ua.inf) begin
                res_d = req_i.a;
              end else if (ub.inf) begin
                res_d = req_i.b;
              end else if (ua.zero && ub.zero) begin
                res_d = {ua.s & ub.s, 31'd0};
              end else if (ua.zero) begin
                res_d = req_i.b;
              end else if (ub.zero) begin
                res_d = req_i.a;
              end else begin
                state_d = F_ADD;
              end
            end
            OP_MUL: begin
              if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
                res_d = CanonNan;
              end else if (ua.inf || ub.inf) begin
                res_d = {ua.s ^ ub.s, 8'hFF, 23'd0};
              end else if (ua.zero || ub.zero) begin
                res_d = {ua.s ^ ub.s, 31'd0};
              end else begin
                state_d = F_MUL;
              end
            end
            OP_DIV: begin
              if (ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
                res_d = CanonNan;
              end else if (ua.inf || ub.zero) begin
                res_d = {ua.s ^ ub.s, 8'hFF, 23'd0};
              end else if (ua.zero || ub.inf) begin
                res_d = {ua.s ^ ub.s, 31'd0};
              end else begin
                state_d = F_DPRE;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end
      F_ADD: begin
        acc_d = sum_v;
        sgn_d = (xs == ys) ? xs : ((opa >= opb) ? xs : ys);
        exp_d = xe + $signed(ExpW'(1));
        if (sum_v == '0) begin
          res_d   = '0;
          state_d = F_DONE;
        end else begin
          state_d = F_NORM;
        end
      end
      F_MUL: begin
        acc_d   = {prod, {(NormW-48){1'b0}}};
        exp_d   = $signed(ua_q.e) + $signed(ub_q.e) + $signed(ExpW'(1));
        state_d = F_NORM;
      end
      F_DPRE: begin
        if (!ua_q.m[23]) begin
          ua_d.m = {ua_q.m[22:0], 1'b0};
          ua_d.e = $signed(ua_q.e) - $signed(ExpW'(1));
        end
        if (!ub_q.m[23]) begin
          ub_d.m = {ub_q.m[22:0], 1'b0};
          ub_d.e = $signed(ub_q.e) - $signed(ExpW'(1));
        end
        if (ua_q.m[23] && ub_q.m[23]) begin
          rem_d   = {1'b0, ua_q.m};
          cnt_d   = '0;
          acc_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        acc_d = {acc_q[NormW-2:0], qbit | (last && (rnext != '0))};
        rem_d = rnext;
        cnt_d = cnt_q + CntW'(1);
        if (last) begin
          exp_d   = $signed(ua_q.e) - $signed(ub_q.e);
          state_d = F_NORM;
        end
      end
      F_NORM: begin
        if (acc_q[NormW-1]) begin
          state_d = F_SHIFT;
        end else begin
          acc_d = {acc_q[NormW-2:0], 1'b0};
          exp_d = exp_q - $signed(ExpW'(1));
        end
      end
      F_SHIFT: begin
        m24_d = shd[NormW-1 -: 24];
        grd_d = shd[NormW-25];
        stk_d = (|shd[NormW-26:0]) | lost_r;
        ef_d  = (ebias > $signed(ExpW'(0))) ? ebias[7:0] : 8'd0;
        if (ebias >= $signed(ExpW'(255))) begin
          res_d   = {sgn_q, 8'hFF, 23'd0};
          state_d = F_DONE;
        end else begin
          state_d = F_PACK;
        end
      end
      F_PACK: begin
        res_d   = {sgn_q, ef_q, m24_q[22:0]} + WordW'(grd_q & (stk_q | m24_q[0]));
        state_d = F_DONE;
      end
      F_DONE: begin
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
      ua_q    <= ua_d;
      ub_q    <= ub_d;
      acc_q   <= acc_d;
      exp_q   <= exp_d;
      sgn_q   <= sgn_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      m24_q   <= m24_d;
      grd_q   <= grd_d;
      stk_q   <= stk_d;
      ef_q    <= ef_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pagerank_pull_row_update_unit.sv =====
// Pull-PageRank row update: float32 contribution store, row accumulator, row finish.
// Depends on prpu_pkg, prpu_fpu and prpu_ram.
//
// Usage:
//   s_axis carries one command beat: mode 0 stores score/degree as the contribution
//   of node_index, mode 1 adds the stored contribution of neighbour node_index to the
//   row sum, mode 2 emits base + damping * sum on m_axis and clears the sum. Mode 3
//   is dropped with no effect. The user must write damping and base over APB only
//   while idle; the block does not enforce this. One item is in flight at a time:
//   s_axis_tready is low from acceptance until the item completes. All arithmetic
//   runs on one shared float unit whose normalize and divide loops advance one bit
//   per cycle. The steps of each mode are:
//     mode 0: convert, then a 50-step divide,
//     mode 1: one add, plus the registered store read,
//     mode 2: multiply, then add, mode 3: none.
//   Mode 2 results sit in an output register; a stalled receiver holds the beat,
//   and the block keeps accepting commands until a second result would be needed.
//   Reset sets damping to 0.85, base and the row sum to zero. The contribution store
//   is not cleared; read only entries that were written.
`default_nettype none

module pagerank_pull_row_update_unit
  import prpu_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NodeCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] mode, [13:2] node_index, [45:14] score_bits, [77:46] out_degree
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] row_score_bits
  output logic [WordW-1:0]    m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [WordW-1:0]    pwdata,
  output logic [WordW-1:0]    prdata,
  output logic                pready
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned XW = ((AW > IdxW) ? AW : IdxW) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CVT_GO,
    S_CVT_WT,
    S_DIV_GO,
    S_DIV_WT,
    S_ACC_GO,
    S_ACC_WT,
    S_MUL_GO,
    S_MUL_WT,
    S_FIN_GO,
    S_FIN_WT,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic             inrange_q, inrange_d;
  logic [WordW-1:0] score_q, score_d;
  logic [WordW-1:0] deg_q, deg_d;
  logic [WordW-1:0] tmp_q, tmp_d;
  logic [WordW-1:0] sum_q, sum_d;
  logic [WordW-1:0] damping_q, damping_d;
  logic [WordW-1:0] base_q, base_d;
  logic             ovalid_q, ovalid_d;
  logic [WordW-1:0] odata_q, odata_d;

  logic             accept, cfg_we;
  logic [1:0]       in_mode;
  logic [XW-1:0]    in_idx;
  logic             in_range;
  logic [AW-1:0]    ram_addr;
  logic             ram_we, ram_re;
  logic [WordW-1:0] ram_rdata;
  fpu_req_t         fpu_req;
  fpu_rsp_t         fpu_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tdata[ModeLsb +: 2];
  assign in_idx        = XW'(s_axis_tdata[IdxLsb +: IdxW]);
  assign in_range      = (in_idx < XW'(NODE_COUNT));

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[CfgAddrW-1] == RegBase) ? base_q : damping_q;

  assign ram_addr = (state_q == S_IDLE) ? in_idx[AW-1:0] : idx_q;
  assign ram_re   = accept && (in_mode == MODE_ACC);
  assign ram_we   = (state_q == S_DIV_WT) && fpu_rsp.done && inrange_q;

  prpu_ram #(
    .Width(WordW),
    .Depth(NODE_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(fpu_rsp.res),
    .rdata_o(ram_rdata)
  );

  prpu_fpu u_fpu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fpu_req),
    .rsp_o (fpu_rsp)
  );

  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = OP_ADD;
    fpu_req.a     = sum_q;
    fpu_req.b     = '0;
    case (state_q)
      S_CVT_GO: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = OP_CVT;
        fpu_req.a     = deg_q;
      end
      S_DIV_GO: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = OP_DIV;
        fpu_req.a     = score_q;
        fpu_req.b     = tmp_q;
      end
      S_ACC_GO: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = OP_ADD;
        fpu_req.a     = sum_q;
        fpu_req.b     = inrange_q ? ram_rdata : '0;
      end
      S_MUL_GO: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = OP_MUL;
        fpu_req.a     = damping_q;
        fpu_req.b     = sum_q;
      end
      S_FIN_GO: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = OP_ADD;
        fpu_req.a     = base_q;
        fpu_req.b     = tmp_q;
      end
      default: begin
        fpu_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    inrange_d = inrange_q;
    score_d   = score_q;
    deg_d     = deg_q;
    tmp_d     = tmp_q;
    sum_d     = sum_q;
    damping_d = damping_q;
    base_d    = base_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;

    if (cfg_we) begin
      if (paddr[CfgAddrW-1] == RegBase) begin
        base_d = pwdata;
      end else begin
        damping_d = pwdata;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d     = in_idx[AW-1:0];
          inrange_d = in_range;
          score_d   = s_axis_tdata[ScoreLsb +: WordW];
          deg_d     = s_axis_tdata[DegLsb +: WordW];
          case (in_mode)
            MODE_STORE:  state_d = S_CVT_GO;
            MODE_ACC:    state_d = S_ACC_GO;
            MODE_FINISH: state_d = S_MUL_GO;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_CVT_GO: state_d = S_CVT_WT;
      S_CVT_WT: begin
        if (fpu_rsp.done) begin
          tmp_d   = fpu_rsp.res;
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: state_d = S_DIV_WT;
      S_DIV_WT: begin
        if (fpu_rsp.done) begin
          state_d = S_IDLE;
        end
      end
      S_ACC_GO: state_d = S_ACC_WT;
      S_ACC_WT: begin
        if (fpu_rsp.done) begin
          sum_d   = fpu_rsp.res;
          state_d = S_IDLE;
        end
      end
      S_MUL_GO: state_d = S_MUL_WT;
      S_MUL_WT: begin
        if (fpu_rsp.done) begin
          tmp_d   = fpu_rsp.res;
          state_d = S_FIN_GO;
        end
      end
      S_FIN_GO: state_d = S_FIN_WT;
      S_FIN_WT: begin
        if (fpu_rsp.done) begin
          tmp_d   = fpu_rsp.res;
          sum_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = tmp_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      damping_q <= DampingRst;
      base_q    <= BaseRst;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      inrange_q <= inrange_d;
      score_q   <= score_d;
      deg_q     <= deg_d;
      tmp_q     <= tmp_d;
      sum_q     <= sum_d;
      damping_q <= damping_d;
      base_q    <= base_d;
      ovalid_q  <= ovalid_d;
      odata_q   <= odata_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/prpu_checker.sv =====
// Port-level checks for the pull-PageRank row update unit, bound to the top level.
// Depends on prpu_pkg and pagerank_pull_row_update_unit.
`default_nettype none

module prpu_checker
  import prpu_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [InDataW-1:0]  s_axis_tdata,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [WordW-1:0]    m_axis_tdata,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tdata[1:0] == MODE_STORE || s_axis_tdata[1:0] == MODE_ACC ||
     s_axis_tdata[1:0] == MODE_FINISH) |=> !s_axis_tready)
    else $error("ready right after an accepted command");

  a_apb_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("APB access without pready");

endmodule

bind pagerank_pull_row_update_unit prpu_checker u_prpu_checker (.*);

`default_nettype wire
